// ----- rtl/wts_pkg.sv -----
// ----------------------------------------------------------------------------
// wts_pkg: shared widths and constants for the world-to-screen projector
// Fixed-point widths of the clip values, the divider operands and the
// saturation helper used on the final screen coordinates.
// ----------------------------------------------------------------------------
package wts_pkg;

	localparam int POS_W    = 32;              // Q16.16 world coordinates
	localparam int COEF_W   = 32;              // Q8.24 coefficients
	localparam int COEF_CNT = 12;              // three rows of four
	localparam int COEF_IW  = 4;               // coefficient slot index width
	localparam int SIZE_W   = 14;              // viewport size registers
	localparam int PROD_W   = POS_W + COEF_W;  // exact product, Q24.40
	localparam int CLIP_W   = 58;              // clip sums in Q.32
	localparam int MAG_W    = CLIP_W - 1;      // clip magnitude and divisor
	localparam int HALF_W   = 29;              // low part of the split magnitude
	localparam int T_W      = SIZE_W + 15;     // size scaled by 2^15
	localparam int NUM_W    = MAG_W + T_W;     // dividend width
	localparam int Q_BITS   = 40;              // quotient bits before the cap
	localparam int QUOT_W   = Q_BITS + 1;      // capped quotient
	localparam int SUM_W    = 44;              // screen sum before saturation
	localparam int OUT_W    = 32;

	// 0.01 in Q.32
	localparam logic signed [CLIP_W-1:0] W_MIN = CLIP_W'(42949673);

	localparam logic [0:0] CMD_LOAD    = 1'b0;
	localparam logic [0:0] CMD_PROJECT = 1'b1;

	function automatic logic [OUT_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'(64'sd2147483647);
		lo = -SUM_W'(64'sd2147483648);
		if (v > hi) begin
			return hi[OUT_W-1:0];
		end else if (v < lo) begin
			return lo[OUT_W-1:0];
		end else begin
			return v[OUT_W-1:0];
		end
	endfunction

endpackage

// ----- rtl/wts_dot.sv -----
// ----------------------------------------------------------------------------
// wts_dot: clip-space dot products
// Two stages: nine exact coefficient products, then the floored row sums
// with the translation term added.
// ----------------------------------------------------------------------------
module wts_dot (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic                                   in_valid,
	input  logic signed [wts_pkg::POS_W-1:0]       pos_x,
	input  logic signed [wts_pkg::POS_W-1:0]       pos_y,
	input  logic signed [wts_pkg::POS_W-1:0]       pos_z,
	input  logic signed [wts_pkg::COEF_W-1:0]      coefs [wts_pkg::COEF_CNT],
	output logic                                   out_valid,
	output logic signed [wts_pkg::CLIP_W-1:0]      cx,
	output logic signed [wts_pkg::CLIP_W-1:0]      cy,
	output logic signed [wts_pkg::CLIP_W-1:0]      cw
);

	logic signed [wts_pkg::POS_W-1:0]  pos [3];
	logic signed [wts_pkg::PROD_W-1:0] prod_s1 [9];
	logic signed [wts_pkg::COEF_W-1:0] trans_s1 [3];
	logic                              v_s1;
	logic signed [wts_pkg::CLIP_W-1:0] sum [3];
	logic signed [wts_pkg::CLIP_W-1:0] sum_s2 [3];
	logic                              v_s2;

	assign pos[0] = pos_x;
	assign pos[1] = pos_y;
	assign pos[2] = pos_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s1[r*3+c] <= wts_pkg::PROD_W'(coefs[r*4+c]) *
						wts_pkg::PROD_W'(pos[c]);
				end
				trans_s1[r] <= coefs[r*4+3];
			end
		end
	end

	// An arithmetic shift right by eight floors the Q24.40 product to Q.32.
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sum[r] = wts_pkg::CLIP_W'(prod_s1[r*3]   >>> 8) +
			         wts_pkg::CLIP_W'(prod_s1[r*3+1] >>> 8) +
			         wts_pkg::CLIP_W'(prod_s1[r*3+2] >>> 8) +
			         wts_pkg::CLIP_W'($signed({trans_s1[r], 8'b0}));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				sum_s2[r] <= sum[r];
			end
		end
	end

	assign out_valid = v_s2;
	assign cx        = sum_s2[0];
	assign cy        = sum_s2[1];
	assign cw        = sum_s2[2];

endmodule

// ----- rtl/wts_div.sv -----
// ----------------------------------------------------------------------------
// wts_div: pipelined restoring divider with quotient cap
// One overflow check stage, then one quotient bit per stage.
// ----------------------------------------------------------------------------
module wts_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_valid,
	input  logic [wts_pkg::NUM_W-1:0]       num,
	input  logic [wts_pkg::MAG_W-1:0]       den,
	input  logic                            in_neg,
	input  logic                            in_vis,
	output logic                            out_valid,
	output logic [wts_pkg::QUOT_W-1:0]      quot,
	output logic                            out_neg,
	output logic                            out_vis
);

	localparam int QB  = wts_pkg::Q_BITS;
	localparam int RW  = wts_pkg::MAG_W;

	logic [RW-1:0]  rem_s  [QB+1];
	logic [QB-1:0]  low_s  [QB+1];
	logic [QB-1:0]  q_s    [QB+1];
	logic [RW-1:0]  den_s  [QB+1];
	logic           sat_s  [QB+1];
	logic           neg_s  [QB+1];
	logic           vis_s  [QB+1];
	logic           v_s    [QB+1];
	logic [RW-1:0]  hi_num;

	assign hi_num = RW'(num[wts_pkg::NUM_W-1:QB]);

	// Entry stage: a quotient at or above 2^40 shows up as the top part of the
	// dividend already reaching the divisor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sat_s[0] <= (hi_num >= den);
			rem_s[0] <= hi_num;
			low_s[0] <= num[QB-1:0];
			q_s[0]   <= '0;
			den_s[0] <= den;
			neg_s[0] <= in_neg;
			vis_s[0] <= in_vis;
		end
	end

	for (genvar k = 1; k <= QB; k++) begin : g_bit
		logic [RW:0] trial;
		logic        ge;

		assign trial = {rem_s[k-1], low_s[k-1][QB-1]};
		assign ge    = (trial >= {1'b0, den_s[k-1]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? RW'(trial - {1'b0, den_s[k-1]}) : RW'(trial);
				low_s[k] <= {low_s[k-1][QB-2:0], 1'b0};
				q_s[k]   <= {q_s[k-1][QB-2:0], ge};
				den_s[k] <= den_s[k-1];
				sat_s[k] <= sat_s[k-1];
				neg_s[k] <= neg_s[k-1];
				vis_s[k] <= vis_s[k-1];
			end
		end
	end

	assign out_valid = v_s[QB];
	assign quot      = sat_s[QB] ? {1'b1, {QB{1'b0}}} : {1'b0, q_s[QB]};
	assign out_neg   = neg_s[QB];
	assign out_vis   = vis_s[QB];

endmodule

// ----- rtl/perspective_world_to_screen.sv -----
// An accepted project request runs through all stages into the output register.
// Throughput: one request per unstalled cycle, set by the 40-stage quotient pipeline.
// A stalled output freezes the whole pipeline together with the input side.
// Load requests write the coefficient store and produce no result.
// Reset clears all coefficients and sets the viewport to 1920 by 1080.
// ----------------------------------------------------------------------------
// perspective_world_to_screen: fixed-point perspective projection
// Dot products, visibility test, scaled division and viewport mapping.
// ----------------------------------------------------------------------------
module perspective_world_to_screen (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [0:0]     cfg_index,
	input  logic [13:0]    cfg_data,
	input  logic           s_axis_tvalid,
	output logic           s_axis_tready,
	// tdata: coef_index[3:0], coef_value[35:4], pos_x[67:36], pos_y[99:68],
	// pos_z[131:100], zero fill to 136 bits
	input  logic [135:0]   s_axis_tdata,
	// tuser: command
	input  logic           s_axis_tuser,
	output logic           m_axis_tvalid,
	input  logic           m_axis_tready,
	// tdata: screen_x[31:0], screen_y[63:32]
	output logic [63:0]    m_axis_tdata,
	// tuser: visible
	output logic           m_axis_tuser
);

	localparam int SW = wts_pkg::SIZE_W;
	localparam int MW = wts_pkg::MAG_W;
	localparam int HW = wts_pkg::HALF_W;
	localparam int TW = wts_pkg::T_W;
	localparam int NW = wts_pkg::NUM_W;
	localparam int UW = wts_pkg::SUM_W;

	localparam logic [0:0] REG_WIDTH  = 1'b0;
	localparam logic [0:0] REG_HEIGHT = 1'b1;

	// Configuration registers.
	logic [SW-1:0] width_q;
	logic [SW-1:0] height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SW'(1920);
			height_q <= SW'(1080);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default:    width_q  <= width_q;
			endcase
		end
	end

	// The whole pipeline moves together whenever the output register can
	// take a new result.
	logic en;
	logic accept;
	logic is_load;
	logic is_proj;

	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign is_load       = accept && (s_axis_tuser == wts_pkg::CMD_LOAD);
	assign is_proj       = accept && (s_axis_tuser == wts_pkg::CMD_PROJECT);

	// Coefficient store. A load updates it at the accept edge, so a project
	// request accepted later always sees it, and one accepted at the same
	// edge or before sees the old value.
	logic signed [wts_pkg::COEF_W-1:0] coef_q [wts_pkg::COEF_CNT];
	logic [wts_pkg::COEF_IW-1:0]       load_idx;

	assign load_idx = s_axis_tdata[3:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < wts_pkg::COEF_CNT; i++) begin
				coef_q[i] <= '0;
			end
		end else if (is_load && (load_idx < wts_pkg::COEF_IW'(wts_pkg::COEF_CNT))) begin
			coef_q[load_idx] <= $signed(s_axis_tdata[35:4]);
		end
	end

	// Stages 1 and 2: clip-space dot products.
	logic                              dot_v;
	logic signed [wts_pkg::CLIP_W-1:0] cx;
	logic signed [wts_pkg::CLIP_W-1:0] cy;
	logic signed [wts_pkg::CLIP_W-1:0] cw;

	wts_dot u_dot (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (is_proj),
		.pos_x     ($signed(s_axis_tdata[67:36])),
		.pos_y     ($signed(s_axis_tdata[99:68])),
		.pos_z     ($signed(s_axis_tdata[131:100])),
		.coefs     (coef_q),
		.out_valid (dot_v),
		.cx        (cx),
		.cy        (cy),
		.cw        (cw)
	);

	// Stage 3: visibility test and sign/magnitude split of the clip values.
	logic          v_s3;
	logic          vis_s3;
	logic          negx_s3;
	logic          negy_s3;
	logic [MW-1:0] magx_s3;
	logic [MW-1:0] magy_s3;
	logic [MW-1:0] den_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= dot_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vis_s3  <= (cw >= wts_pkg::W_MIN);
			negx_s3 <= cx[wts_pkg::CLIP_W-1];
			negy_s3 <= cy[wts_pkg::CLIP_W-1];
			magx_s3 <= cx[wts_pkg::CLIP_W-1] ? MW'(-cx) : MW'(cx);
			magy_s3 <= cy[wts_pkg::CLIP_W-1] ? MW'(-cy) : MW'(cy);
			den_s3  <= MW'(cw);
		end
	end

	// Stage 4: the magnitude times size*2^15, as two partial products each.
	logic [TW-1:0]      tx;
	logic [TW-1:0]      ty;
	logic               v_s4;
	logic               vis_s4;
	logic               negx_s4;
	logic               negy_s4;
	logic [MW-1:0]      den_s4;
	logic [HW+TW-1:0]   pxl_s4;
	logic [MW-HW+TW-1:0] pxh_s4;
	logic [HW+TW-1:0]   pyl_s4;
	logic [MW-HW+TW-1:0] pyh_s4;

	assign tx = {width_q, 15'b0};
	assign ty = {height_q, 15'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vis_s4  <= vis_s3;
			negx_s4 <= negx_s3;
			negy_s4 <= negy_s3;
			den_s4  <= den_s3;
			pxl_s4  <= (HW+TW)'(magx_s3[HW-1:0]) * (HW+TW)'(tx);
			pxh_s4  <= (MW-HW+TW)'(magx_s3[MW-1:HW]) * (MW-HW+TW)'(tx);
			pyl_s4  <= (HW+TW)'(magy_s3[HW-1:0]) * (HW+TW)'(ty);
			pyh_s4  <= (MW-HW+TW)'(magy_s3[MW-1:HW]) * (MW-HW+TW)'(ty);
		end
	end

	// Stage 5: combine the partial products into the dividends.
	logic          v_s5;
	logic          vis_s5;
	logic          negx_s5;
	logic          negy_s5;
	logic [MW-1:0] den_s5;
	logic [NW-1:0] numx_s5;
	logic [NW-1:0] numy_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vis_s5  <= vis_s4;
			negx_s5 <= negx_s4;
			negy_s5 <= negy_s4;
			den_s5  <= den_s4;
			numx_s5 <= NW'(pxl_s4) + (NW'(pxh_s4) << HW);
			numy_s5 <= NW'(pyl_s4) + (NW'(pyh_s4) << HW);
		end
	end

	// Stages 6 to 46: one divider per screen axis over the same divisor.
	// An invisible point may carry a zero or negative divisor; its quotient is
	// discarded at the output.
	logic                      divx_v;
	logic                      divy_v;
	logic [wts_pkg::QUOT_W-1:0] qx;
	logic [wts_pkg::QUOT_W-1:0] qy;
	logic                      negx_d;
	logic                      negy_d;
	logic                      visx_d;
	logic                      visy_d;

	wts_div u_div_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s5),
		.num       (numx_s5),
		.den       (den_s5),
		.in_neg    (negx_s5),
		.in_vis    (vis_s5),
		.out_valid (divx_v),
		.quot      (qx),
		.out_neg   (negx_d),
		.out_vis   (visx_d)
	);

	wts_div u_div_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s5),
		.num       (numy_s5),
		.den       (den_s5),
		.in_neg    (negy_s5),
		.in_vis    (vis_s5),
		.out_valid (divy_v),
		.quot      (qy),
		.out_neg   (negy_d),
		.out_vis   (visy_d)
	);

	// Output stage: apply the signs, add the viewport offsets and saturate; invisible points give zero.
	// x = q + (W + 1) * 2^15 and y = (H - 1) * 2^15 - q, both in Q16.16.
	logic signed [UW-1:0] sqx;
	logic signed [UW-1:0] sqy;
	logic signed [UW-1:0] offx;
	logic signed [UW-1:0] offy;
	logic signed [UW-1:0] sumx;
	logic signed [UW-1:0] sumy;
	logic                 out_v_q;
	logic                 vis_q;
	logic [31:0]          sx_q;
	logic [31:0]          sy_q;

	assign sqx  = negx_d ? -$signed(UW'(qx)) : $signed(UW'(qx));
	assign sqy  = negy_d ? -$signed(UW'(qy)) : $signed(UW'(qy));
	assign offx = $signed(UW'({(SW+1)'(width_q) + (SW+1)'(1), 15'b0}));
	assign offy = $signed(UW'({height_q, 15'b0})) - $signed(UW'(32768));
	assign sumx = sqx + offx;
	assign sumy = offy - sqy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= divx_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vis_q <= visx_d;
			sx_q  <= visx_d ? wts_pkg::sat32(sumx) : '0;
			sy_q  <= visx_d ? wts_pkg::sat32(sumy) : '0;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tuser  = vis_q;
	assign m_axis_tdata  = {sy_q, sx_q};

`ifndef SYNTH
	// Both dividers run in lock step on the same requests.
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(divx_v == divy_v) && (!divx_v || (visx_d == visy_d)))
		else $error("divider pipelines out of step");

	// An invisible point reports both coordinates as zero.
	a_invisible_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 64'd0))
		else $error("invisible point with non-zero coordinates");

	// A load request never starts work in the dot-product pipeline.
	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		is_load |=> !u_dot.v_s1)
		else $error("load request entered the pipeline");
`endif

endmodule
